[sv/twm_pkg.sv]
// Shared constants and control types for the trapezoid weight map.
package twm_pkg;

  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DRIVER_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVER_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_END    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_START  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_END    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LOW  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HIGH = 3'd7;

  // Registers that reset to 1.0 rather than 0
  localparam logic [NUM_REGS-1:0] RESET_ONE_MASK = 8'b1011_1010;

  // Quotient bits resolved per divider stage
  localparam int DIV_STEPS = 2;

  typedef struct packed {
    logic valid;
    logic use_ramp;
    logic neg;
    logic ovf;
  } twm_ctl_t;

endpackage

[sv/trapezoid_weight_map_core.sv]
// Top level of the trapezoid weight map: config, pipeline and output stage.
// Throughput: one weight per cycle unless the output stalls; the divider resolves two quotient bits per stage.
// A stalled output holds the whole pipeline; dropped transactions leave a bubble.
// Reset clears all valid bits and loads the register reset values (1.0 or 0).
module trapezoid_weight_map_core #(
  parameter int FRAC_BITS    = 12,
  parameter int WEIGHT_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [twm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [WEIGHT_WIDTH-1:0]          cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [WEIGHT_WIDTH-1:0]   weight_in_i,
  input  logic                             animating_i,
  input  logic                             target_animates_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [WEIGHT_WIDTH-1:0]   driver_weight_o,
  output logic signed [WEIGHT_WIDTH-1:0]   mapped_weight_o
);

  localparam int W    = WEIGHT_WIDTH;
  localparam int SW   = 3 * W;
  localparam int QW   = W + 2;
  localparam int SUMW = W + 4;

  localparam logic signed [SUMW-1:0] SMAX = SUMW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic signed [SUMW-1:0] SMIN = -SMAX - SUMW'(1);
  localparam logic signed [W-1:0]    WMAX = SMAX[W-1:0];

  logic [twm_pkg::NUM_REGS-1:0][W-1:0] cfg;
  logic en;
  logic out_valid_q;

  // advance everything unless the finished transaction is held
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = out_valid_q && out_stall_i;

  twm_cfg_regs #(.W(W), .FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  logic signed [W:0] fr_a, fr_b, fr_d;
  twm_pkg::twm_ctl_t fr_ctl;
  logic [SW-1:0]     fr_side;

  twm_front #(.W(W)) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .in_valid_i        (in_valid_i),
    .weight_i          (weight_in_i),
    .animating_i       (animating_i),
    .target_animates_i (target_animates_i),
    .cfg_i             (cfg),
    .a_o               (fr_a),
    .b_o               (fr_b),
    .d_o               (fr_d),
    .ctl_o             (fr_ctl),
    .side_o            (fr_side)
  );

  logic [2*W:0]      mu_num;
  logic [W:0]        mu_den;
  twm_pkg::twm_ctl_t mu_ctl;
  logic [SW-1:0]     mu_side;

  twm_mul #(.W(W), .SW(SW)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .a_i    (fr_a),
    .b_i    (fr_b),
    .d_i    (fr_d),
    .ctl_i  (fr_ctl),
    .side_i (fr_side),
    .num_o  (mu_num),
    .den_o  (mu_den),
    .ctl_o  (mu_ctl),
    .side_o (mu_side)
  );

  logic [QW-1:0]     dv_quo;
  twm_pkg::twm_ctl_t dv_ctl;
  logic [SW-1:0]     dv_side;

  twm_div #(.W(W), .SW(SW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .num_i  (mu_num),
    .den_i  (mu_den),
    .ctl_i  (mu_ctl),
    .side_i (mu_side),
    .quo_o  (dv_quo),
    .ctl_o  (dv_ctl),
    .side_o (dv_side)
  );

  // Signed quotient, pinned to full scale on overflow
  logic [QW-1:0]          qsat;
  logic signed [QW:0]     sq_d;
  twm_pkg::twm_ctl_t      f1_ctl_q;
  logic signed [QW:0]     f1_sq_q;
  logic [SW-1:0]          f1_side_q;

  assign qsat = dv_ctl.ovf ? '1 : dv_quo;
  assign sq_d = dv_ctl.neg ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_ctl_q <= '0;
    end else if (en) begin
      f1_ctl_q <= dv_ctl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_sq_q   <= sq_d;
      f1_side_q <= dv_side;
    end
  end

  // Offset add and saturation on the ramp, direct value otherwise
  logic signed [W-1:0]    offset, direct;
  logic signed [SUMW-1:0] sum;
  logic signed [W-1:0]    driven_d;
  logic signed [W-1:0]    driver_q, driven_q;

  assign offset = f1_side_q[2*W-1:W];
  assign direct = f1_side_q[W-1:0];
  assign sum    = SUMW'(offset) + SUMW'(f1_sq_q);

  always_comb begin
    if (!f1_ctl_q.use_ramp) begin
      driven_d = direct;
    end else if (sum > SMAX) begin
      driven_d = SMAX[W-1:0];
    end else if (sum < SMIN) begin
      driven_d = SMIN[W-1:0];
    end else begin
      driven_d = sum[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= f1_ctl_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      driver_q <= f1_side_q[3*W-1:2*W];
      driven_q <= driven_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign driver_weight_o = driver_q;
  assign mapped_weight_o = driven_q;

`ifndef SYNTHESIS
  a_stall_needs_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> out_valid_o
  ) else $error("input stalled with no result held");

  a_direct_passes: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (en && f1_ctl_q.valid && !f1_ctl_q.use_ramp)
      |=> (mapped_weight_o == $past(f1_side_q[W-1:0]))
  ) else $error("plateau or outside value not passed through");

  a_overflow_saturates: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (en && f1_ctl_q.valid && f1_ctl_q.use_ramp && f1_ctl_q.ovf && !f1_ctl_q.neg)
      |=> (mapped_weight_o == WMAX)
  ) else $error("positive quotient overflow did not saturate");
`endif

endmodule

[sv/twm_cfg_regs.sv]
// Configuration register file for the trapezoid weight map.
module twm_cfg_regs #(
  parameter int W         = 16,
  parameter int FRAC_BITS = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [twm_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [W-1:0]                          cfg_data_i,
  output logic [twm_pkg::NUM_REGS-1:0][W-1:0]   cfg_o
);

  localparam logic [W-1:0] ONE = W'(64'd1 << FRAC_BITS);

  logic [twm_pkg::NUM_REGS-1:0][W-1:0] regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < twm_pkg::NUM_REGS; i++) begin
        regs_q[i] <= twm_pkg::RESET_ONE_MASK[i] ? ONE : '0;
      end
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign cfg_o = regs_q;

endmodule

[sv/twm_front.sv]
// Clamp stage and trapezoid segment selection with ramp operand setup.
module twm_front #(
  parameter int W = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  in_valid_i,
  input  logic signed [W-1:0]                   weight_i,
  input  logic                                  animating_i,
  input  logic                                  target_animates_i,
  input  logic [twm_pkg::NUM_REGS-1:0][W-1:0]   cfg_i,
  output logic signed [W:0]                     a_o,
  output logic signed [W:0]                     b_o,
  output logic signed [W:0]                     d_o,
  output twm_pkg::twm_ctl_t                     ctl_o,
  output logic [3*W-1:0]                        side_o
);

  logic signed [W-1:0] dlo, dhi, r0, r1, f0, f1, lo, hi;

  assign dlo = cfg_i[twm_pkg::REG_DRIVER_LOW];
  assign dhi = cfg_i[twm_pkg::REG_DRIVER_HIGH];
  assign r0  = cfg_i[twm_pkg::REG_RISE_START];
  assign r1  = cfg_i[twm_pkg::REG_RISE_END];
  assign f0  = cfg_i[twm_pkg::REG_FALL_START];
  assign f1  = cfg_i[twm_pkg::REG_FALL_END];
  assign lo  = cfg_i[twm_pkg::REG_TARGET_LOW];
  assign hi  = cfg_i[twm_pkg::REG_TARGET_HIGH];

  // Stage 1: clamp
  logic                valid1_q;
  logic                anim1_q;
  logic signed [W-1:0] w1_q;
  logic signed [W-1:0] w1_d;

  always_comb begin
    w1_d = weight_i;
    if (!animating_i) begin
      if (weight_i < dlo) begin
        w1_d = dlo;
      end else if (weight_i > dhi) begin
        w1_d = dhi;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else if (en_i) begin
      // drop the transaction when an animating driver meets a fixed target
      valid1_q <= in_valid_i && !(animating_i && !target_animates_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      anim1_q <= animating_i;
      w1_q    <= w1_d;
    end
  end

  // Stage 2: segment select
  logic signed [W:0]   rise_a, rise_b, rise_d, fall_a, fall_b, fall_d;
  logic                use_ramp, use_rise;
  logic signed [W-1:0] direct;

  assign rise_a = $signed({w1_q[W-1], w1_q}) - $signed({r0[W-1], r0});
  assign rise_b = $signed({hi[W-1], hi}) - $signed({lo[W-1], lo});
  assign rise_d = $signed({r1[W-1], r1}) - $signed({r0[W-1], r0});
  assign fall_a = $signed({w1_q[W-1], w1_q}) - $signed({f0[W-1], f0});
  assign fall_b = $signed({lo[W-1], lo}) - $signed({hi[W-1], hi});
  assign fall_d = $signed({f1[W-1], f1}) - $signed({f0[W-1], f0});

  always_comb begin
    use_ramp = 1'b0;
    use_rise = 1'b1;
    direct   = lo;
    if (anim1_q && (w1_q < r0)) begin
      // extrapolate the rising ramp only when its foot sits on the driver bound
      if (r0 == dlo) begin
        if (r0 == r1) begin
          direct = hi;
        end else begin
          use_ramp = 1'b1;
        end
      end
    end else if (anim1_q && (w1_q > f1)) begin
      if (f1 == dhi) begin
        if (f1 == f0) begin
          direct = hi;
        end else begin
          use_ramp = 1'b1;
          use_rise = 1'b0;
        end
      end
    end else if (w1_q <= r0) begin
      direct = ((r0 == r1) && (r0 <= dlo)) ? hi : lo;
    end else if (w1_q <= r1) begin
      use_ramp = 1'b1;
    end else if (w1_q <= f0) begin
      direct = hi;
    end else if (w1_q <= f1) begin
      use_ramp = 1'b1;
      use_rise = 1'b0;
    end else begin
      direct = (f0 >= dhi) ? hi : lo;
    end
  end

  twm_pkg::twm_ctl_t ctl2_q;
  logic signed [W:0] a2_q, b2_q, d2_q;
  logic [3*W-1:0]    side2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
    end else if (en_i) begin
      // valid, use_ramp, neg, ovf
      ctl2_q <= {valid1_q, use_ramp, 1'b0, 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a2_q    <= use_rise ? rise_a : fall_a;
      b2_q    <= use_rise ? rise_b : fall_b;
      d2_q    <= use_rise ? rise_d : fall_d;
      side2_q <= {w1_q, (use_rise ? lo : hi), direct};
    end
  end

  assign a_o    = a2_q;
  assign b_o    = b2_q;
  assign d_o    = d2_q;
  assign ctl_o  = ctl2_q;
  assign side_o = side2_q;

endmodule

[sv/twm_mul.sv]
// Ramp product and sign-magnitude split for the divider.
module twm_mul #(
  parameter int W  = 16,
  parameter int SW = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic signed [W:0]  a_i,
  input  logic signed [W:0]  b_i,
  input  logic signed [W:0]  d_i,
  input  twm_pkg::twm_ctl_t  ctl_i,
  input  logic [SW-1:0]      side_i,
  output logic [2*W:0]       num_o,
  output logic [W:0]         den_o,
  output twm_pkg::twm_ctl_t  ctl_o,
  output logic [SW-1:0]      side_o
);

  localparam int PW = 2 * W + 2;
  localparam int NW = 2 * W + 1;

  // Stage 3: multiply
  twm_pkg::twm_ctl_t  ctl3_q;
  logic signed [PW-1:0] p3_q;
  logic signed [W:0]  d3_q;
  logic [SW-1:0]      side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
    end else if (en_i) begin
      ctl3_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p3_q    <= PW'(a_i) * PW'(b_i);
      d3_q    <= d_i;
      side3_q <= side_i;
    end
  end

  // Stage 4: magnitudes
  logic [PW-1:0] pmag;
  logic [W:0]    dmag;

  assign pmag = p3_q[PW-1] ? PW'(-p3_q) : PW'(p3_q);
  assign dmag = d3_q[W] ? (W+1)'(-d3_q) : (W+1)'(d3_q);

  twm_pkg::twm_ctl_t ctl4_d;
  twm_pkg::twm_ctl_t ctl4_q;
  logic [NW-1:0]     n4_q;
  logic [W:0]        d4_q;
  logic [SW-1:0]     side4_q;

  always_comb begin
    ctl4_d     = ctl3_q;
    ctl4_d.neg = p3_q[PW-1] ^ d3_q[W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl4_q <= '0;
    end else if (en_i) begin
      ctl4_q <= ctl4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n4_q    <= pmag[NW-1:0];
      d4_q    <= dmag;
      side4_q <= side3_q;
    end
  end

  assign num_o  = n4_q;
  assign den_o  = d4_q;
  assign ctl_o  = ctl4_q;
  assign side_o = side4_q;

endmodule

[sv/twm_div.sv]
// Pipelined restoring divider with quotient overflow detect.
module twm_div #(
  parameter int W  = 16,
  parameter int SW = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [2*W:0]       num_i,
  input  logic [W:0]         den_i,
  input  twm_pkg::twm_ctl_t  ctl_i,
  input  logic [SW-1:0]      side_i,
  output logic [W+1:0]       quo_o,
  output twm_pkg::twm_ctl_t  ctl_o,
  output logic [SW-1:0]      side_o
);

  localparam int NW   = 2 * W + 1;
  localparam int DW   = W + 1;
  localparam int QW   = W + 2;
  localparam int K    = twm_pkg::DIV_STEPS;
  localparam int NSTG = (QW + K - 1) / K;

  logic [DW-1:0]     rem_q  [NSTG+1];
  logic [QW-1:0]     quo_q  [NSTG+1];
  logic [QW-1:0]     num_q  [NSTG+1];
  logic [DW-1:0]     den_q  [NSTG+1];
  twm_pkg::twm_ctl_t ctl_q  [NSTG+1];
  logic [SW-1:0]     side_q [NSTG+1];

  logic [DW-1:0]     top_bits;
  twm_pkg::twm_ctl_t ctl0_d;

  // dividend bits above the quotient range seed the remainder
  assign top_bits = DW'(num_i[NW-1:QW]);

  always_comb begin
    ctl0_d     = ctl_i;
    ctl0_d.ovf = (top_bits >= den_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
    end else if (en_i) begin
      ctl_q[0] <= ctl0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= top_bits;
      quo_q[0]  <= '0;
      num_q[0]  <= num_i[QW-1:0];
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    logic [DW-1:0] rem_d;
    logic [QW-1:0] quo_d;
    logic [QW-1:0] num_d;

    always_comb begin
      logic [DW:0] t;
      rem_d = rem_q[s];
      quo_d = quo_q[s];
      num_d = num_q[s];
      t     = '0;
      for (int k = 0; k < K; k++) begin
        if (s * K + k < QW) begin
          t     = {rem_d, num_d[QW-1]};
          num_d = {num_d[QW-2:0], 1'b0};
          if (t >= {1'b0, den_q[s]}) begin
            t     = t - {1'b0, den_q[s]};
            quo_d = {quo_d[QW-2:0], 1'b1};
          end else begin
            quo_d = {quo_d[QW-2:0], 1'b0};
          end
          rem_d = t[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s+1] <= '0;
      end else if (en_i) begin
        ctl_q[s+1] <= ctl_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= rem_d;
        quo_q[s+1]  <= quo_d;
        num_q[s+1]  <= num_d;
        den_q[s+1]  <= den_q[s];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign quo_o  = quo_q[NSTG];
  assign ctl_o  = ctl_q[NSTG];
  assign side_o = side_q[NSTG];

endmodule
